FILE: design/priority_process_queue_macros.svh
// Assertion macros shared by the priority process queue RTL.
`ifndef PRIORITY_PROCESS_QUEUE_MACROS_SVH
`define PRIORITY_PROCESS_QUEUE_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Expression must never be true outside reset.
`define PPQ_ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

FILE: design/ppq_pkg.sv
// Types and constants of the priority process queue.
package ppq_pkg;

  localparam int unsigned DEPTH = 16;

  localparam logic MODE_ADD  = 1'b0;
  localparam logic MODE_EXEC = 1'b1;

  typedef enum logic [1:0] {
    ST_ADDED    = 2'd0,
    ST_EXECUTED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef struct packed {
    logic        mode;
    logic [15:0] proc_id;
    logic [7:0]  priority_req;
  } in_t;

  typedef struct packed {
    status_e     status;
    logic [15:0] out_proc_id;
    logic [7:0]  out_priority;
  } out_t;

  typedef struct packed {
    logic [15:0] proc_id;
    logic [7:0]  prio;
  } entry_t;

  // Broadcast to every cell for one queue operation.
  typedef struct packed {
    logic   ins;
    logic   pop;
    entry_t new_entry;
  } cell_ctrl_t;

endpackage

FILE: design/ppq_cell.sv
// One slot of the sorted queue chain: holds an entry, shifts right on insert, left on pop.
module ppq_cell (
  input  logic                clk_i,
  input  ppq_pkg::cell_ctrl_t ctrl_i,
  input  logic                occupied_i,
  input  ppq_pkg::entry_t     left_entry_i,
  input  logic                left_go_i,
  input  ppq_pkg::entry_t     right_entry_i,
  output ppq_pkg::entry_t     entry_o,
  output logic                go_o
);

  ppq_pkg::entry_t entry_q, entry_d;

  // Yield this slot when it is free or holds a strictly lower priority;
  // equal priorities stay ahead so the earlier entry wins.
  assign go_o = !occupied_i || (entry_q.prio < ctrl_i.new_entry.prio);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.pop) begin
      entry_d = right_entry_i;
    end else if (ctrl_i.ins && go_o) begin
      entry_d = left_go_i ? left_entry_i : ctrl_i.new_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: design/priority_process_queue.sv
// An accepted item is held in the request register ahead of the cell chain, then applied.
// Its result shows for one cycle; no new item is taken while busy, i.e. while one is held.
// Each chain operation (sorted insert or pop of the head) updates all cells in the same cycle.
// Reset clears the entry count, request and result strobes; cell contents are not reset.
// Results cannot be stalled by the receiver.
`include "priority_process_queue_macros.svh"

module priority_process_queue #(
  parameter int unsigned DEPTH = ppq_pkg::DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  ppq_pkg::in_t  req_i,
  output logic          result_valid_o,
  output ppq_pkg::out_t res_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  ppq_pkg::in_t        req_q;
  logic                req_valid_q;
  logic [CntW-1:0]     count_q, count_d;
  ppq_pkg::out_t       res_q, res_d;
  logic                result_valid_q;
  logic                is_full, is_empty;
  ppq_pkg::cell_ctrl_t ctrl;

  ppq_pkg::entry_t     cell_entry [DEPTH];
  logic [DEPTH-1:0]    cell_go;
  logic [DEPTH-1:0]    occupied;

  assign busy     = req_valid_q;
  assign is_full  = (count_q == CntW'(DEPTH));
  assign is_empty = (count_q == '0);

  always_comb begin
    ctrl.ins       = req_valid_q && (req_q.mode == ppq_pkg::MODE_ADD) && !is_full;
    ctrl.pop       = req_valid_q && (req_q.mode == ppq_pkg::MODE_EXEC) && !is_empty;
    ctrl.new_entry = '{proc_id: req_q.proc_id, prio: req_q.priority_req};
  end

  always_comb begin
    count_d = count_q;
    res_d   = '{status: ppq_pkg::ST_ADDED, out_proc_id: '0, out_priority: '0};
    if (req_q.mode == ppq_pkg::MODE_ADD) begin
      if (is_full) begin
        res_d.status = ppq_pkg::ST_FULL;
      end else begin
        count_d = count_q + 1'b1;
      end
    end else if (is_empty) begin
      res_d.status = ppq_pkg::ST_EMPTY;
    end else begin
      // Head cell always holds the highest, earliest-added entry.
      res_d.status       = ppq_pkg::ST_EXECUTED;
      res_d.out_proc_id  = cell_entry[0].proc_id;
      res_d.out_priority = cell_entry[0].prio;
      count_d            = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q    <= 1'b0;
      result_valid_q <= 1'b0;
      count_q        <= '0;
    end else begin
      result_valid_q <= req_valid_q;
      if (req_valid_q) begin
        req_valid_q <= 1'b0;
        count_q     <= count_d;
      end else if (start) begin
        req_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !req_valid_q) begin
      req_q <= req_i;
    end
    if (req_valid_q) begin
      res_q <= res_d;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < DEPTH; gi++) begin : g_cell
      ppq_pkg::entry_t left_entry, right_entry;
      logic            left_go;

      assign occupied[gi] = (count_q > CntW'(gi));

      if (gi == 0) begin : g_head
        assign left_entry = '0;
        assign left_go    = 1'b0;
      end else begin : g_mid
        assign left_entry = cell_entry[gi-1];
        assign left_go    = cell_go[gi-1];
      end

      if (gi == DEPTH - 1) begin : g_tail
        assign right_entry = '0;
      end else begin : g_body
        assign right_entry = cell_entry[gi+1];
      end

      ppq_cell u_cell (
        .clk_i         (clk_i),
        .ctrl_i        (ctrl),
        .occupied_i    (occupied[gi]),
        .left_entry_i  (left_entry),
        .left_go_i     (left_go),
        .right_entry_i (right_entry),
        .entry_o       (cell_entry[gi]),
        .go_o          (cell_go[gi])
      );
    end
  endgenerate

  assign result_valid_o = result_valid_q;
  assign res_o          = res_q;

  `PPQ_ASSERT_NEVER(a_count_bound, count_q > CntW'(DEPTH), "entry count above depth")
  `PPQ_ASSERT(a_req_busy, start && !busy |=> busy, "accepted item did not raise busy")
  `PPQ_ASSERT(a_req_result, busy |=> result_valid_o && !busy, "item produced no result")
  `PPQ_ASSERT(a_exec_nonempty, result_valid_o && res_o.status == ppq_pkg::ST_EXECUTED |-> $past(count_q) != '0, "executed from empty queue")
  `PPQ_ASSERT(a_add_count, result_valid_o && res_o.status == ppq_pkg::ST_ADDED |-> count_q == $past(count_q) + 1'b1, "add did not grow the queue")

endmodule

FILE: verif/ppq_checker.sv
// Checker for the priority process queue: predicts each result and compares it.
module ppq_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic          busy_i,
  input  ppq_pkg::in_t  req_i,
  input  logic          res_valid_i,
  input  ppq_pkg::out_t res_i,
  input  logic          done_i,
  output int            fail_count_o,
  output int            pending_o
);

  ppq_pkg::entry_t sched_q[$];
  ppq_pkg::out_t   expected_q[$];
  int              fail_count;
  logic            done_seen;

  task automatic report_mismatch(input string what);
    $display("%0t: mismatch: %s", $time, what);
    fail_count++;
  endtask

  // Apply one item to the shadow queue and return the result it should give.
  function automatic ppq_pkg::out_t dispatch_outcome(input ppq_pkg::in_t item);
    ppq_pkg::out_t   res;
    ppq_pkg::entry_t ent;
    int              best;
    res = '0;
    if (item.mode == ppq_pkg::MODE_ADD) begin
      if (sched_q.size() >= ppq_pkg::DEPTH) begin
        res.status = ppq_pkg::ST_FULL;
      end else begin
        ent.proc_id = item.proc_id;
        ent.prio    = item.priority_req;
        sched_q.push_back(ent);
        res.status = ppq_pkg::ST_ADDED;
      end
    end else if (sched_q.size() == 0) begin
      res.status = ppq_pkg::ST_EMPTY;
    end else begin
      // strict compare keeps the earliest entry among equal priorities
      best = 0;
      for (int i = 1; i < sched_q.size(); i++) begin
        if (sched_q[i].prio > sched_q[best].prio) best = i;
      end
      res.status       = ppq_pkg::ST_EXECUTED;
      res.out_proc_id  = sched_q[best].proc_id;
      res.out_priority = sched_q[best].prio;
      sched_q.delete(best);
    end
    return res;
  endfunction

  always @(posedge clk_i) begin
    ppq_pkg::out_t want;
    if (!rst_ni) begin
      sched_q.delete();
      expected_q.delete();
      fail_count = 0;
      done_seen  = 1'b0;
    end else begin
      if (start_i && !busy_i) expected_q.push_back(dispatch_outcome(req_i));
      if (res_valid_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result status=%0d id=%h prio=%h",
                                    res_i.status, res_i.out_proc_id, res_i.out_priority));
        end else begin
          want = expected_q.pop_front();
          if (res_i.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d", res_i.status, want.status));
          if (res_i.out_proc_id !== want.out_proc_id)
            report_mismatch($sformatf("proc id got %h want %h",
                                      res_i.out_proc_id, want.out_proc_id));
          if (res_i.out_priority !== want.out_priority)
            report_mismatch($sformatf("priority got %h want %h",
                                      res_i.out_priority, want.out_priority));
        end
      end
      if (done_i && !done_seen) begin
        done_seen = 1'b1;
        if (expected_q.size() != 0)
          report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= expected_q.size();
  end

endmodule

FILE: verif/tb_top.sv
// Testbench top for the priority process queue: stimulus, checker hookup and verdict.
module tb_top;

  localparam int unsigned NUM_RANDOM = 1400;

  logic          clk_i;
  logic          rst_ni;
  logic          start;
  logic          busy;
  ppq_pkg::in_t  req;
  logic          result_valid;
  ppq_pkg::out_t res;
  logic          done;
  int            fail_count;
  int            pending;

  priority_process_queue i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_i          (req),
    .result_valid_o (result_valid),
    .res_o          (res)
  );

  ppq_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .req_i        (req),
    .res_valid_i  (result_valid),
    .res_i        (res),
    .done_i       (done),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic ppq_pkg::in_t make_add(input logic [15:0] id, input logic [7:0] prio);
    ppq_pkg::in_t item;
    item.mode         = ppq_pkg::MODE_ADD;
    item.proc_id      = id;
    item.priority_req = prio;
    return item;
  endfunction

  // Execute items carry random id and priority, which the block must ignore.
  function automatic ppq_pkg::in_t make_exec();
    ppq_pkg::in_t item;
    item.mode         = ppq_pkg::MODE_EXEC;
    item.proc_id      = 16'($urandom_range(0, 65535));
    item.priority_req = 8'($urandom_range(0, 255));
    return item;
  endfunction

  // Drive one item after an optional idle gap and hold it until accepted.
  task automatic send_item(input ppq_pkg::in_t item, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req   <= item;
    do @(posedge clk_i); while (busy);
  endtask

  function automatic logic [7:0] pick_prio(input int prio_mode);
    case (prio_mode)
      0: return 8'($urandom_range(0, 3));
      1: return 8'($urandom_range(0, 255));
      2: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      default: return 8'($urandom_range(252, 255));
    endcase
  endfunction

  initial begin
    int sent;
    int phase_len;
    int add_pct;
    int prio_mode;
    int gap;
    bit idle_on;
    ppq_pkg::in_t item;

    rst_ni = 1'b0;
    start  = 1'b0;
    req    = '0;
    done   = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty execute, field extremes, ties resolved by insertion order
    send_item(make_exec(), 0);
    send_item(make_add(16'hFFFF, 8'hFF), 0);
    send_item(make_add(16'h0000, 8'h00), 0);
    send_item(make_add(16'hA5A5, 8'hFF), 2);
    send_item(make_add(16'h5A5A, 8'h80), 0);
    send_item(make_add(16'h0001, 8'hFF), 0);
    repeat (6) send_item(make_exec(), 0);
    send_item(make_add(16'h1234, 8'h00), 0);
    send_item(make_add(16'h4321, 8'h00), 1);
    send_item(make_exec(), 0);
    send_item(make_exec(), 3);
    send_item(make_exec(), 0);

    // random phases: add-heavy ones hit the full queue, execute-heavy ones drain it
    sent = 0;
    while (sent < NUM_RANDOM) begin
      phase_len = $urandom_range(20, 80);
      case ($urandom_range(0, 4))
        0: add_pct = 90;
        1: add_pct = 70;
        2: add_pct = 50;
        3: add_pct = 30;
        default: add_pct = 10;
      endcase
      prio_mode = $urandom_range(0, 3);
      idle_on   = (sent < NUM_RANDOM - 200) && ($urandom_range(0, 3) != 0);
      for (int k = 0; k < phase_len; k++) begin
        if ($urandom_range(1, 100) <= add_pct)
          item = make_add(16'($urandom_range(0, 65535)), pick_prio(prio_mode));
        else
          item = make_exec();
        gap = (idle_on && $urandom_range(0, 2) == 0) ? $urandom_range(1, 13) : 0;
        send_item(item, gap);
        sent++;
      end
    end
    start <= 1'b0;

    // drain, then allow the result latency before closing
    for (int w = 0; w < 200 && pending != 0; w++) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    done <= 1'b1;
    repeat (2) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
